>>> design/yrs_pkg.sv
// Shared types and constants for the YUYV to RGB565 nearest-neighbor scaler.
// Used by the selector, the queue, the converter and the top level.
// No dependencies.
`default_nettype none

package yrs_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_SRC_WIDTH_PAIRS = 3'd0,
        CFG_DST_WIDTH_PAIRS = 3'd1,
        CFG_OUT_LINES       = 3'd2,
        CFG_X_STEP          = 3'd3,
        CFG_Y_STEP          = 3'd4
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;

    localparam logic [10:0] RST_SRC_WIDTH_PAIRS = 11'd320;
    localparam logic [10:0] RST_DST_WIDTH_PAIRS = 11'd88;
    localparam logic [11:0] RST_OUT_LINES       = 12'd220;
    localparam logic [27:0] RST_X_STEP          = 28'd238313;
    localparam logic [27:0] RST_Y_STEP          = 28'd142988;

    localparam logic [27:0] STEP_MIN = 28'd65536;
    localparam logic [27:0] STEP_MAX = 28'd134217728;

    // Compare widths that hold both a register value and the largest line limits.
    localparam int PAIR_CMP_W = 13;
    localparam int LINE_CMP_W = 14;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

    typedef struct packed {
        logic [10:0] src_width_pairs;
        logic [10:0] dst_width_pairs;
        logic [11:0] out_lines;
        logic [27:0] x_step;
        logic [27:0] y_step;
    } t_scale_cfg;

    // One selected macropixel on its way to the converter.
    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
        logic       frame_last;
    } t_sel_item;

endpackage

`default_nettype wire

>>> design/yrs_select.sv
// Front part: tracks source and output positions and picks the macropixels
// that nearest-neighbor downscaling keeps. Depends on yrs_pkg.
`default_nettype none

module yrs_select
    import yrs_pkg::*;
#(
    parameter int MAX_LINE_PAIRS = 1024,
    parameter int MAX_LINES      = 2048
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_scale_cfg i_cfg,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_luma_first,
    input  wire logic [7:0] i_chroma_blue,
    input  wire logic [7:0] i_luma_second,
    input  wire logic [7:0] i_chroma_red,
    input  wire logic       i_frame_start,
    input  wire logic       i_full,
    output logic            o_push,
    output t_sel_item       o_item
);

    localparam int COL_W  = $clog2(MAX_LINE_PAIRS);
    localparam int SROW_W = $clog2(MAX_LINES + 1);
    localparam int OROW_W = $clog2(MAX_LINES);
    localparam int H_W    = COL_W + 29;
    localparam int V_W    = OROW_W + 28;

    logic [COL_W-1:0]  r_src_col, n_src_col, c_src_col;
    logic [SROW_W-1:0] r_src_row, n_src_row, c_src_row;
    logic [H_W-1:0]    r_hacc, n_hacc, c_hacc;
    logic [V_W-1:0]    r_vacc, n_vacc, c_vacc;
    logic [COL_W-1:0]  r_out_col, n_out_col, c_out_col;
    logic [OROW_W-1:0] r_out_row, n_out_row, c_out_row;
    logic              r_done, n_done, c_done;

    logic [PAIR_CMP_W-1:0] srcw, dstw, srcw_raw, dstw_raw;
    logic [LINE_CMP_W-1:0] dsth, dsth_raw;
    logic [27:0]           xs, ys;
    logic                  accept, clear, col_hit, row_hit, sel, last_col, last_row;

    // Registers act as limited to their legal ranges.
    always_comb begin
        srcw_raw = PAIR_CMP_W'(i_cfg.src_width_pairs);
        dstw_raw = PAIR_CMP_W'(i_cfg.dst_width_pairs);
        dsth_raw = LINE_CMP_W'(i_cfg.out_lines);

        if (srcw_raw == '0) begin
            srcw = PAIR_CMP_W'(1);
        end else if (srcw_raw > PAIR_CMP_W'(MAX_LINE_PAIRS)) begin
            srcw = PAIR_CMP_W'(MAX_LINE_PAIRS);
        end else begin
            srcw = srcw_raw;
        end

        if (dstw_raw == '0) begin
            dstw = PAIR_CMP_W'(1);
        end else if (dstw_raw > PAIR_CMP_W'(MAX_LINE_PAIRS)) begin
            dstw = PAIR_CMP_W'(MAX_LINE_PAIRS);
        end else begin
            dstw = dstw_raw;
        end

        if (dsth_raw == '0) begin
            dsth = LINE_CMP_W'(1);
        end else if (dsth_raw > LINE_CMP_W'(MAX_LINES)) begin
            dsth = LINE_CMP_W'(MAX_LINES);
        end else begin
            dsth = dsth_raw;
        end

        if (i_cfg.x_step < STEP_MIN) begin
            xs = STEP_MIN;
        end else if (i_cfg.x_step > STEP_MAX) begin
            xs = STEP_MAX;
        end else begin
            xs = i_cfg.x_step;
        end

        if (i_cfg.y_step < STEP_MIN) begin
            ys = STEP_MIN;
        end else if (i_cfg.y_step > STEP_MAX) begin
            ys = STEP_MAX;
        end else begin
            ys = i_cfg.y_step;
        end
    end

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign clear   = i_frame_start;

    always_comb begin
        // A frame start clears the position state before the item is judged.
        c_src_col = clear ? '0 : r_src_col;
        c_src_row = clear ? '0 : r_src_row;
        c_hacc    = clear ? '0 : r_hacc;
        c_vacc    = clear ? '0 : r_vacc;
        c_out_col = clear ? '0 : r_out_col;
        c_out_row = clear ? '0 : r_out_row;
        c_done    = clear ? 1'b0 : r_done;

        // The wanted column is the accumulator over 2^17: pixel position
        // halved to a pair, which also rounds it down to an even pixel.
        col_hit  = c_hacc[H_W-1:17] == (H_W - 17)'(c_src_col);
        row_hit  = c_vacc[V_W-1:16] == (V_W - 16)'(c_src_row);
        sel      = !c_done && col_hit && row_hit;
        last_col = (PAIR_CMP_W'(c_out_col) + PAIR_CMP_W'(1)) >= dstw;
        last_row = (LINE_CMP_W'(c_out_row) + LINE_CMP_W'(1)) >= dsth;

        n_hacc    = c_hacc;
        n_vacc    = c_vacc;
        n_out_col = c_out_col;
        n_out_row = c_out_row;
        n_done    = c_done;

        if (sel) begin
            if (last_col) begin
                n_out_col = '0;
                n_hacc    = '0;
                if (last_row) begin
                    n_done = 1'b1;
                end else begin
                    n_out_row = c_out_row + OROW_W'(1);
                    n_vacc    = c_vacc + V_W'(ys);
                end
            end else begin
                n_out_col = c_out_col + COL_W'(1);
                n_hacc    = c_hacc + H_W'({xs, 1'b0});
            end
        end

        n_src_row = c_src_row;
        if ((PAIR_CMP_W'(c_src_col) + PAIR_CMP_W'(1)) >= srcw) begin
            n_src_col = '0;
            if (c_src_row < SROW_W'(MAX_LINES)) begin
                n_src_row = c_src_row + SROW_W'(1);
            end
        end else begin
            n_src_col = c_src_col + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col <= '0;
            r_src_row <= '0;
            r_hacc    <= '0;
            r_vacc    <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_done    <= 1'b0;
        end else if (accept) begin
            r_src_col <= n_src_col;
            r_src_row <= n_src_row;
            r_hacc    <= n_hacc;
            r_vacc    <= n_vacc;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_done    <= n_done;
        end
    end

    assign o_push             = accept && sel;
    assign o_item.luma_first  = i_luma_first;
    assign o_item.chroma_blue = i_chroma_blue;
    assign o_item.luma_second = i_luma_second;
    assign o_item.chroma_red  = i_chroma_red;
    assign o_item.frame_last  = last_col && last_row;

endmodule

`default_nettype wire

>>> design/yrs_fifo.sv
// Short queue of selected macropixels between the selector and the converter.
// Depends on yrs_pkg.
`default_nettype none

module yrs_fifo
    import yrs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_sel_item i_item,
    output logic           o_full,
    output logic           o_valid,
    input  wire logic      i_pop,
    output t_sel_item      o_item
);

    t_sel_item               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [FIFO_PTR_W:0]     r_count;
    logic                    do_pop;

    assign o_full  = r_count == (FIFO_PTR_W + 1)'(FIFO_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + (FIFO_PTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (FIFO_PTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/yrs_convert.sv
// Back part: two-stage YUV to RGB565 conversion of a pixel pair with an
// output register that holds the result while the receiver stalls. Depends on yrs_pkg.
`default_nettype none

module yrs_convert
    import yrs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_sel_item i_item,
    output logic           o_valid,
    input  wire logic      i_ready,
    output logic [15:0]    o_pixel_first,
    output logic [15:0]    o_pixel_second,
    output logic           o_frame_last
);

    // Q2.14 coefficients: 1.402, 0.344, 0.714, 1.772.
    localparam logic signed [15:0] COEF_RV = 16'sd22970;
    localparam logic signed [15:0] COEF_GU = 16'sd5636;
    localparam logic signed [15:0] COEF_GV = 16'sd11698;
    localparam logic signed [15:0] COEF_BU = 16'sd29032;

    logic signed [8:0]  s_u, s_v;
    logic               s1_en, s2_en;

    logic               r_s1_valid;
    logic [7:0]         r_s1_y0, r_s1_y1;
    logic               r_s1_last;
    logic signed [23:0] r_prod_rv, r_prod_gu, r_prod_gv, r_prod_bu;

    logic               r_out_valid;
    logic [15:0]        r_pix0, r_pix1;
    logic               r_last;
    logic [15:0]        n_pix0, n_pix1;

    // Clamps a Q.14 sum to 0..255 and drops the fraction.
    function automatic logic [7:0] channel(input logic signed [24:0] sum);
        logic [7:0] c;
        if (sum[24]) begin
            c = 8'd0;
        end else if (sum[23:22] != 2'b00) begin
            c = 8'd255;
        end else begin
            c = sum[21:14];
        end
        return c;
    endfunction

    function automatic logic [15:0] pack565(
        input logic [7:0]         y,
        input logic signed [23:0] rv,
        input logic signed [23:0] gu,
        input logic signed [23:0] gv,
        input logic signed [23:0] bu
    );
        logic signed [24:0] base, sr, sg, sb;
        logic [7:0]         r, g, b;
        base = $signed({3'b000, y, 14'b0});
        sr   = base + 25'(rv);
        sg   = base - 25'(gu) - 25'(gv);
        sb   = base + 25'(bu);
        r    = channel(sr);
        g    = channel(sg);
        b    = channel(sb);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    assign s2_en   = !r_out_valid || i_ready;
    assign s1_en   = !r_s1_valid || s2_en;
    assign o_ready = s1_en;

    assign s_u = $signed({1'b0, i_item.chroma_blue}) - 9'sd128;
    assign s_v = $signed({1'b0, i_item.chroma_red}) - 9'sd128;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_en) begin
            r_s1_valid <= i_valid;
        end
    end

    // Chroma products are shared by both pixels of the pair.
    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_s1_y0   <= i_item.luma_first;
            r_s1_y1   <= i_item.luma_second;
            r_s1_last <= i_item.frame_last;
            r_prod_rv <= 24'(COEF_RV) * 24'(s_v);
            r_prod_gu <= 24'(COEF_GU) * 24'(s_u);
            r_prod_gv <= 24'(COEF_GV) * 24'(s_v);
            r_prod_bu <= 24'(COEF_BU) * 24'(s_u);
        end
    end

    always_comb begin
        n_pix0 = pack565(r_s1_y0, r_prod_rv, r_prod_gu, r_prod_gv, r_prod_bu);
        n_pix1 = pack565(r_s1_y1, r_prod_rv, r_prod_gu, r_prod_gv, r_prod_bu);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_en) begin
            r_pix0 <= n_pix0;
            r_pix1 <= n_pix1;
            r_last <= r_s1_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pixel_first  = r_pix0;
    assign o_pixel_second = r_pix1;
    assign o_frame_last   = r_last;

endmodule

`default_nettype wire

>>> design/yuyv_to_rgb565_nearest_scaler.sv
// Top level of the YUYV to RGB565 nearest-neighbor downscaler.
// Holds the configuration registers and connects yrs_select, yrs_fifo and
// yrs_convert. Depends on yrs_pkg.
//   Input stream: one YUYV macropixel per transfer on s_axis; tuser marks the
//   first macropixel of a source frame. The block drops macropixels that the
//   downscaler does not keep and turns each kept one into two RGB565 pixels.
//   Output stream: one pixel pair per transfer on m_axis; tlast marks the last
//   pair of the output frame.
//   Configuration: write i_cfg_data to register i_cfg_index while i_cfg_we is
//   high; only while the stream is idle.
//   Throughput: one input transfer per cycle, sustained. The selector decides
//   within the accepting cycle, so nothing limits the rate but the handshakes.
//   Path: a kept macropixel passes a queue entry, then the product stage, then
//   the output register, whose valid flag drives m_axis_tvalid.
//   Stall: m_axis holds its data while tready is low; the conversion stages
//   and the four-entry queue fill, then s_axis_tready drops. Dropped
//   macropixels take no queue space but are accepted only while it has room.
//   Reset: registers return to their default sizes (640 by 480 source to
//   176 by 220 output), position counters clear and the first frame behaves
//   as if it had started.
`default_nettype none

module yuyv_to_rgb565_nearest_scaler
    import yrs_pkg::*;
#(
    parameter int MAX_LINE_PAIRS = 1024,
    parameter int MAX_LINES      = 2048
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [7:0] luma_first, [15:8] chroma_blue, [23:16] luma_second, [31:24] chroma_red
    input  wire logic [31:0]           s_axis_tdata,
    // [0] frame_start
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [15:0] pixel_first, [31:16] pixel_second
    output logic [31:0]                m_axis_tdata,
    output logic                       m_axis_tlast
);

    t_scale_cfg r_cfg;
    t_sel_item  push_item, head_item;
    logic       push, fifo_full, head_valid, conv_ready;
    logic [15:0] pix0, pix1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width_pairs <= RST_SRC_WIDTH_PAIRS;
            r_cfg.dst_width_pairs <= RST_DST_WIDTH_PAIRS;
            r_cfg.out_lines       <= RST_OUT_LINES;
            r_cfg.x_step          <= RST_X_STEP;
            r_cfg.y_step          <= RST_Y_STEP;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SRC_WIDTH_PAIRS: r_cfg.src_width_pairs <= i_cfg_data[10:0];
                CFG_DST_WIDTH_PAIRS: r_cfg.dst_width_pairs <= i_cfg_data[10:0];
                CFG_OUT_LINES:       r_cfg.out_lines       <= i_cfg_data[11:0];
                CFG_X_STEP:          r_cfg.x_step          <= i_cfg_data[27:0];
                CFG_Y_STEP:          r_cfg.y_step          <= i_cfg_data[27:0];
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

    yrs_select #(
        .MAX_LINE_PAIRS (MAX_LINE_PAIRS),
        .MAX_LINES      (MAX_LINES)
    ) u_select (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_luma_first  (s_axis_tdata[7:0]),
        .i_chroma_blue (s_axis_tdata[15:8]),
        .i_luma_second (s_axis_tdata[23:16]),
        .i_chroma_red  (s_axis_tdata[31:24]),
        .i_frame_start (s_axis_tuser),
        .i_full        (fifo_full),
        .o_push        (push),
        .o_item        (push_item)
    );

    yrs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (fifo_full),
        .o_valid (head_valid),
        .i_pop   (conv_ready),
        .o_item  (head_item)
    );

    yrs_convert u_convert (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (head_valid),
        .o_ready        (conv_ready),
        .i_item         (head_item),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_pixel_first  (pix0),
        .o_pixel_second (pix1),
        .o_frame_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {pix1, pix0};

endmodule

`default_nettype wire
